@@ design/spce_pkg.sv @@
// Shared types, constants and helper functions for the spinal code encoder.
package spce_pkg;

    localparam int unsigned MAX_CHUNK_BITS = 8;
    localparam int unsigned MAX_PASSES     = 64;
    localparam int unsigned MAX_PRECISION  = 16;

    localparam logic [31:0] MIX_C1  = 32'h9e37_79b9;
    localparam logic [31:0] MIX_C2  = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C3  = 32'hc2b2_ae35;
    localparam logic [31:0] SYM_C1  = 32'h2722_0a95;
    localparam logic [31:0] SYM_C2  = 32'hed5a_d4bb;

    typedef enum logic [1:0] {
        REG_SEED      = 2'd0,
        REG_BITS_STEP = 2'd1,
        REG_PASSES    = 2'd2,
        REG_PRECISION = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [3:0]  bits_per_step;
        logic [6:0]  pass_count;
        logic [4:0]  symbol_precision;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_NONE = 4'd0,
        ST_MIX0 = 4'd1,
        ST_MIX1 = 4'd2,
        ST_MIX2 = 4'd3,
        ST_SYM0 = 4'd4,
        ST_SYM1 = 4'd5,
        ST_SYM2 = 4'd6,
        ST_SYM3 = 4'd7,
        ST_SYM4 = 4'd8,
        ST_SYM5 = 4'd9
    } step_t;

    typedef struct packed {
        step_t      step;
        logic       in_load;
        logic [5:0] pass_idx;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    function automatic logic [6:0] eff_passes(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > 7'(MAX_PASSES)) begin
            r = 7'(MAX_PASSES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [4:0] eff_prec(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > 5'(MAX_PRECISION)) begin
            r = 5'(MAX_PRECISION);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [7:0] chunk_mask(input logic [3:0] k);
        logic [4:0] ks;
        ks = ({1'b0, k} > 5'(MAX_CHUNK_BITS)) ? 5'(MAX_CHUNK_BITS) : {1'b0, k};
        return 8'((17'd1 << ks) - 17'd1);
    endfunction

    // floor(2^32 / (2^p + 1))
    function automatic logic [31:0] recip(input logic [4:0] p);
        logic [31:0] r;
        case (p)
            5'd1:    r = 32'h5555_5555;
            5'd2:    r = 32'h3333_3333;
            5'd3:    r = 32'h1C71_C71C;
            5'd4:    r = 32'h0F0F_0F0F;
            5'd5:    r = 32'h07C1_F07C;
            5'd6:    r = 32'h03F0_3F03;
            5'd7:    r = 32'h01FC_07F0;
            5'd8:    r = 32'h00FF_00FF;
            5'd9:    r = 32'h007F_C01F;
            5'd10:   r = 32'h003F_F003;
            5'd11:   r = 32'h001F_FC00;
            5'd12:   r = 32'h000F_FF00;
            5'd13:   r = 32'h0007_FFC0;
            5'd14:   r = 32'h0003_FFF0;
            5'd15:   r = 32'h0001_FFFC;
            5'd16:   r = 32'h0000_FFFF;
            default: r = 32'h5555_5555;
        endcase
        return r;
    endfunction

endpackage

@@ design/spce_cfg.sv @@
// APB register file holding the encoder configuration.
module spce_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output spce_pkg::cfg_t     cfg
);
    import spce_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_SEED:      cfg_next.seed             = pwdata;
                REG_BITS_STEP: cfg_next.bits_per_step    = pwdata[3:0];
                REG_PASSES:    cfg_next.pass_count       = pwdata[6:0];
                REG_PRECISION: cfg_next.symbol_precision = pwdata[4:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SEED:      prdata = cfg_reg.seed;
            REG_BITS_STEP: prdata = {28'd0, cfg_reg.bits_per_step};
            REG_PASSES:    prdata = {25'd0, cfg_reg.pass_count};
            REG_PRECISION: prdata = {27'd0, cfg_reg.symbol_precision};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seed             <= 32'd0;
            cfg_reg.bits_per_step    <= 4'd4;
            cfg_reg.pass_count       <= 7'd1;
            cfg_reg.symbol_precision <= 5'd8;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/spce_ctrl.sv @@
// Controller: sequences the spine update and the per-pass symbol steps.
module spce_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [6:0]         pass_count,
    input  spce_pkg::stat_t    stat,
    output spce_pkg::cmd_t     cmd
);
    import spce_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MIX0 = 10'b00_0000_0010,
        S_MIX1 = 10'b00_0000_0100,
        S_MIX2 = 10'b00_0000_1000,
        S_SYM0 = 10'b00_0001_0000,
        S_SYM1 = 10'b00_0010_0000,
        S_SYM2 = 10'b00_0100_0000,
        S_SYM3 = 10'b00_1000_0000,
        S_SYM4 = 10'b01_0000_0000,
        S_SYM5 = 10'b10_0000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [5:0] pass_reg;
    logic [5:0] pass_next;
    logic [6:0] passes;
    logic       last;

    assign passes   = eff_passes(pass_count);
    assign last     = ({1'b0, pass_reg} + 7'd1) == passes;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        cmd.step     = ST_NONE;
        cmd.in_load  = 1'b0;
        cmd.pass_idx = pass_reg;
        cmd.last     = last;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_MIX0;
                end
            end
            S_MIX0: begin
                cmd.step   = ST_MIX0;
                state_next = S_MIX1;
            end
            S_MIX1: begin
                cmd.step   = ST_MIX1;
                state_next = S_MIX2;
            end
            S_MIX2: begin
                cmd.step   = ST_MIX2;
                pass_next  = 6'd0;
                state_next = S_SYM0;
            end
            S_SYM0: begin
                cmd.step   = ST_SYM0;
                state_next = S_SYM1;
            end
            S_SYM1: begin
                cmd.step   = ST_SYM1;
                state_next = S_SYM2;
            end
            S_SYM2: begin
                cmd.step   = ST_SYM2;
                state_next = S_SYM3;
            end
            S_SYM3: begin
                cmd.step   = ST_SYM3;
                state_next = S_SYM4;
            end
            S_SYM4: begin
                cmd.step   = ST_SYM4;
                state_next = S_SYM5;
            end
            S_SYM5: begin
                cmd.step = ST_SYM5;
                if (stat.out_free) begin
                    if (last) begin
                        state_next = S_IDLE;
                    end else begin
                        pass_next  = pass_reg + 6'd1;
                        state_next = S_SYM0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg  <= 6'd0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

@@ design/spce_dp.sv @@
// Datapath: spine register, shared multiplier, modulo reduction, output register.
module spce_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  spce_pkg::cmd_t     cmd,
    output spce_pkg::stat_t    stat,
    input  spce_pkg::cfg_t     cfg,
    input  logic [7:0]         in_chunk,
    input  logic               in_start,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast
);
    import spce_pkg::*;

    logic [7:0]  chunk_reg;
    logic        start_reg;
    logic [31:0] spine_reg;
    logic [31:0] spine_next;
    logic [63:0] prod_reg;
    logic [31:0] x_reg;
    logic [17:0] r_reg;
    logic        vld_reg;
    logic        vld_next;
    logic [16:0] sym_reg;
    logic [5:0]  pidx_reg;
    logic        last_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic [31:0] h;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] q;
    logic [31:0] qm;
    logic [31:0] rem_full;
    logic [4:0]  prec;
    logic [15:0] half;
    logic [17:0] modulus;
    logic [17:0] r_corr;
    logic [16:0] sym_val;
    logic        out_load;

    assign prec    = eff_prec(cfg.symbol_precision);
    assign half    = 16'(17'd1 << (prec - 5'd1));
    assign modulus = 18'(18'd1 << prec) + 18'd1;

    assign stat.out_free = !vld_reg || m_tready;
    assign out_load      = (cmd.step == ST_SYM5) && stat.out_free;

    always_comb begin
        mul_a      = prod_reg[31:0];
        mul_b      = 32'd0;
        mul_en     = 1'b0;
        spine_next = spine_reg;
        h          = start_reg ? cfg.seed : spine_reg;
        t0         = 32'd0;
        t1         = 32'd0;
        case (cmd.step)
            ST_MIX0: begin
                t0     = h ^ (32'(chunk_reg & chunk_mask(cfg.bits_per_step)) + MIX_C1
                              + (h << 6) + (h >> 2));
                mul_a  = t0 ^ (t0 >> 16);
                mul_b  = MIX_C2;
                mul_en = 1'b1;
            end
            ST_MIX1: begin
                mul_a  = prod_reg[31:0] ^ (prod_reg[31:0] >> 13);
                mul_b  = MIX_C3;
                mul_en = 1'b1;
            end
            ST_MIX2: begin
                spine_next = prod_reg[31:0] ^ (prod_reg[31:0] >> 16);
            end
            ST_SYM0: begin
                mul_a  = {26'd0, cmd.pass_idx};
                mul_b  = SYM_C1;
                mul_en = 1'b1;
            end
            ST_SYM1: begin
                t1     = spine_reg ^ prod_reg[31:0];
                mul_a  = t1 ^ (t1 >> 17);
                mul_b  = SYM_C2;
                mul_en = 1'b1;
            end
            ST_SYM2: begin
                mul_a  = prod_reg[31:0] ^ (prod_reg[31:0] >> 11);
                mul_b  = MIX_C1;
                mul_en = 1'b1;
            end
            ST_SYM3: begin
                mul_a  = prod_reg[31:0] ^ (prod_reg[31:0] >> 16);
                mul_b  = recip(prec);
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Quotient estimate is at most one short, so one correction step.
    assign q        = prod_reg[63:32];
    assign qm       = (q << prec) + q;
    assign rem_full = x_reg - qm;
    assign r_corr   = (r_reg >= modulus) ? (r_reg - modulus) : r_reg;
    assign sym_val  = r_corr[16:0] - {1'b0, half};

    always_comb begin
        vld_next = vld_reg;
        if (out_load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spine_reg <= 32'd0;
            vld_reg   <= 1'b0;
        end else begin
            spine_reg <= spine_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            chunk_reg <= in_chunk;
            start_reg <= in_start;
        end
        if (mul_en) begin
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        end
        if (cmd.step == ST_SYM3) begin
            x_reg <= mul_a;
        end
        if (cmd.step == ST_SYM4) begin
            r_reg <= rem_full[17:0];
        end
        if (out_load) begin
            sym_reg  <= sym_val;
            pidx_reg <= cmd.pass_idx;
            last_reg <= cmd.last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {1'b0, pidx_reg, sym_reg};
    assign m_tlast  = last_reg;

endmodule

@@ design/spinal_code_encoder_unit.sv @@
// Spinal code encoder top level: APB configuration, input and symbol streams.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready   | tdata[7:0] chunk, tuser start of message
//  m_       | out       | m_tvalid/m_tready   | tdata[16:0] symbol, [22:17] pass, tlast
//  apb      | in        | psel/penable/pready | 4 x 32-bit registers at 0x0..0xC
//
// Per item: an accept in idle, three spine-mix steps and six steps per symbol for
// each effective pass, all on the single shared 32x32 multiplier; no new chunk is
// taken until the item is done. A held symbol that m_tready does not take stalls
// the sequence at the output load. Reset is synchronous; the spine clears to zero.
module spinal_code_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_chunk
    input  logic        s_tuser,   // [0] start_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] symbol, [22:17] pass_index, [23] zero
    output logic        m_tlast,   // last_of_step
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spce_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    spce_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spce_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .pass_count (cfg.pass_count),
        .stat       (stat),
        .cmd        (cmd)
    );

    spce_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg),
        .in_chunk (s_tdata),
        .in_start (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ test/spce_symbol_checker.sv @@
// Watches the encoder ports, predicts the coded symbols and compares them.
`timescale 1ns / 100ps

module spce_symbol_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_chunk
    input  logic        s_tuser,   // [0] start_of_message
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [16:0] symbol, [22:17] pass_index, [23] zero
    input  logic        m_tlast,   // last_of_step
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import spce_pkg::*;

    localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
    localparam logic [31:0] FMIX_M1   = 32'h85eb_ca6b;
    localparam logic [31:0] FMIX_M2   = 32'hc2b2_ae35;
    localparam logic [31:0] PASS_MUL  = 32'h2722_0a95;
    localparam logic [31:0] SCRAMBLE  = 32'hed5a_d4bb;

    typedef struct packed {
        logic [16:0] symbol;
        logic [5:0]  pass_index;
        logic        last_of_step;
    } coded_symbol_t;

    coded_symbol_t expected_symbols[$];

    logic [31:0] seed_reg;
    logic [3:0]  bits_reg;
    logic [6:0]  passes_reg;
    logic [4:0]  precision_reg;
    logic [31:0] spine;

    function automatic logic [31:0] spine_mix(input logic [31:0] h, input logic [31:0] chunk);
        logic [31:0] t;
        t = h ^ (chunk + GOLDEN + (h << 6) + (h >> 2));
        t = t ^ (t >> 16);
        t = t * FMIX_M1;
        t = t ^ (t >> 13);
        t = t * FMIX_M2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    function automatic logic [16:0] symbol_of(input logic [31:0] sp, input logic [5:0] pass,
                                              input logic [4:0] prec);
        logic [31:0] x;
        logic [31:0] half;
        logic [31:0] modulus;
        logic [31:0] rem;
        half    = 32'd1 << (prec - 5'd1);
        modulus = (half << 1) + 32'd1;
        x = sp ^ ({26'd0, pass} * PASS_MUL);
        x = x ^ (x >> 17);
        x = x * SCRAMBLE;
        x = x ^ (x >> 11);
        x = x * GOLDEN;
        x = x ^ (x >> 16);
        rem = x % modulus;
        return 17'(rem - half);
    endfunction

    task automatic encode_chunk(input logic [7:0] chunk, input logic start);
        logic [3:0]    k;
        logic [7:0]    mask;
        int            n;
        logic [4:0]    prec;
        coded_symbol_t sym;
        k    = (bits_reg > 4'd8) ? 4'd8 : bits_reg;
        mask = 8'((9'd1 << k) - 9'd1);
        n    = (passes_reg == 7'd0) ? 1 : (passes_reg > 7'd64) ? 64 : int'(passes_reg);
        prec = (precision_reg == 5'd0) ? 5'd1 :
               (precision_reg > 5'd16) ? 5'd16 : precision_reg;
        if (start) begin
            spine = seed_reg;
        end
        spine = spine_mix(spine, {24'd0, chunk & mask});
        for (int p = 0; p < n; p++) begin
            sym.symbol       = symbol_of(spine, 6'(p), prec);
            sym.pass_index   = 6'(p);
            sym.last_of_step = (p == n - 1);
            expected_symbols.push_back(sym);
        end
    endtask

    task automatic check_symbol();
        coded_symbol_t want;
        coded_symbol_t got;
        got.symbol       = m_tdata[16:0];
        got.pass_index   = m_tdata[22:17];
        got.last_of_step = m_tlast;
        if (expected_symbols.size() == 0) begin
            errors++;
            $display("%0t: unexpected symbol: expected none, got symbol %0d pass %0d last %0b",
                     $time, $signed(got.symbol), got.pass_index, got.last_of_step);
        end else begin
            want = expected_symbols.pop_front();
            if (got.symbol !== want.symbol) begin
                errors++;
                $display("%0t: symbol mismatch: expected %0d, got %0d",
                         $time, $signed(want.symbol), $signed(got.symbol));
            end
            if (got.pass_index !== want.pass_index) begin
                errors++;
                $display("%0t: pass_index mismatch: expected %0d, got %0d",
                         $time, want.pass_index, got.pass_index);
            end
            if (got.last_of_step !== want.last_of_step) begin
                errors++;
                $display("%0t: last_of_step mismatch: expected %0b, got %0b",
                         $time, want.last_of_step, got.last_of_step);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors        = 0;
            seed_reg      = 32'd0;
            bits_reg      = 4'd4;
            passes_reg    = 7'd1;
            precision_reg = 5'd8;
            spine         = 32'd0;
            expected_symbols.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_symbol();
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SEED:      seed_reg      = pwdata;
                    REG_BITS_STEP: bits_reg      = pwdata[3:0];
                    REG_PASSES:    passes_reg    = pwdata[6:0];
                    REG_PRECISION: precision_reg = pwdata[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                encode_chunk(s_tdata, s_tuser);
            end
        end
        pending <= expected_symbols.size();
    end

endmodule

@@ test/tb.sv @@
// Stimulus, handshake pacing and verdict for the spinal code encoder.
`timescale 1ns / 100ps

module tb;
    import spce_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PHASE_ITEMS = 38;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] message_chunk
    logic        s_tuser = 1'b0;   // [0] start_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [16:0] symbol, [22:17] pass_index, [23] zero
    logic        m_tlast;          // last_of_step
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int s_idle_pct = 0;
    int m_stall_pct = 0;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    spinal_code_encoder_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    spce_symbol_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_chunk(input logic [7:0] chunk, input logic start);
        if (s_idle_pct != 0 && $urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= chunk;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // lowers valid and holds off until every predicted symbol has come out
    task automatic wait_all_symbols();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic configure(input logic [31:0] seed, input logic [3:0] bits,
                             input logic [6:0] passes, input logic [4:0] prec);
        wait_all_symbols();
        write_reg(REG_SEED, seed);
        write_reg(REG_BITS_STEP, {28'd0, bits});
        write_reg(REG_PASSES, {25'd0, passes});
        write_reg(REG_PRECISION, {27'd0, prec});
    endtask

    task automatic random_config();
        logic [31:0] seed;
        logic [3:0]  bits;
        logic [6:0]  passes;
        logic [4:0]  prec;
        case ($urandom_range(7))
            0:       seed = 32'd0;
            1:       seed = 32'hffff_ffff;
            default: seed = $urandom;
        endcase
        bits = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        case ($urandom_range(9))
            0:       passes = 7'd0;
            1:       passes = 7'($urandom_range(7, 127));
            default: passes = 7'($urandom_range(1, 6));
        endcase
        prec = 5'($urandom_range(31));
        configure(seed, bits, passes, prec);
    endtask

    initial begin
        int phase;
        int remaining;
        int msg_len;
        bit broken;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, no start marker yet: spine begins at zero
        send_chunk(8'h00, 1'b0);
        send_chunk(8'hff, 1'b0);
        // zero bits, zero passes, zero precision
        configure(32'hffff_ffff, 4'd0, 7'd0, 5'd0);
        send_chunk(8'hff, 1'b1);
        send_chunk(8'h5a, 1'b0);
        // bits, passes and precision above their ranges saturate
        configure(32'hffff_ffff, 4'd15, 7'd127, 5'd31);
        send_chunk(8'hff, 1'b1);
        send_chunk(8'h00, 1'b0);
        configure(32'd0, 4'd8, 7'd64, 5'd16);
        send_chunk(8'h80, 1'b1);
        send_chunk(8'h7f, 1'b0);
        send_chunk(8'hff, 1'b0);
        configure(32'h1234_5678, 4'd1, 7'd2, 5'd1);
        send_chunk(8'hfe, 1'b1);
        send_chunk(8'h01, 1'b0);
        configure(32'h8000_0001, 4'd9, 7'd65, 5'd17);
        send_chunk(8'haa, 1'b1);
        send_chunk(8'h55, 1'b0);
        configure(32'h0f0f_f0f0, 4'd7, 7'd3, 5'd15);
        send_chunk(8'hc3, 1'b1);
        send_chunk(8'h3c, 1'b0);

        for (phase = 0; phase < 8; phase++) begin
            random_config();
            case (phase % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 87; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 87; end
                default: begin s_idle_pct = 37; m_stall_pct = 37; end
            endcase
            remaining = PHASE_ITEMS;
            while (remaining > 0) begin
                msg_len = $urandom_range(1, 12);
                broken  = ($urandom_range(9) == 0);
                for (int i = 0; i < msg_len && remaining > 0; i++) begin
                    if ($urandom_range(39) == 0) begin
                        wait_all_symbols();
                    end
                    send_chunk(8'($urandom_range(255)),
                               broken ? 1'($urandom_range(1)) : (i == 0));
                    remaining--;
                end
            end
        end

        m_stall_pct = 0;
        wait_all_symbols();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ spinal_code_encoder_unit.f @@
design/spce_pkg.sv
design/spce_cfg.sv
design/spce_ctrl.sv
design/spce_dp.sv
design/spinal_code_encoder_unit.sv
test/spce_symbol_checker.sv
test/tb.sv
